@@ src/vurp_pkg.sv @@
package vurp_pkg;

  // Memory sizes.
  localparam int NameBytes    = 2048;
  localparam int NameAw       = $clog2(NameBytes);
  localparam int SpriteBytes  = 256;
  localparam int SpriteAw     = $clog2(SpriteBytes);
  localparam int PaletteBytes = 32;
  localparam int PaletteAw    = $clog2(PaletteBytes);

  // VRAM address map.
  localparam logic [15:0] NameBase      = 16'h2000;
  localparam logic [15:0] MirrorLo      = 16'h3000;
  localparam logic [15:0] MirrorHi      = 16'h3EFF;
  localparam logic [15:0] MirrorOffset  = 16'h1000;
  localparam logic [15:0] PaletteBase   = 16'h3F00;
  localparam logic [15:0] PaletteHi     = 16'h3FFF;
  localparam logic [15:0] NameLimit     = 16'(NameBytes);
  localparam logic [7:0]  UnmappedByte  = 8'hFF;
  localparam logic [15:0] StepNarrow    = 16'd1;
  localparam logic [15:0] StepWide      = 16'd32;

  // Operation codes of an input word.
  typedef enum logic [2:0] {
    OP_REG_WRITE    = 3'd0,
    OP_REG_READ     = 3'd1,
    OP_DMA_WRITE    = 3'd2,
    OP_VBLANK_ENTER = 3'd3,
    OP_VBLANK_LEAVE = 3'd4,
    OP_NMI_ACK      = 3'd5
  } vurp_op_e;

  // Register selects.
  typedef enum logic [2:0] {
    SEL_CONTROL     = 3'd0,
    SEL_MASK        = 3'd1,
    SEL_STATUS      = 3'd2,
    SEL_SPRITE_ADDR = 3'd3,
    SEL_SPRITE_DATA = 3'd4,
    SEL_SCROLL      = 3'd5,
    SEL_ADDRESS     = 3'd6,
    SEL_DATA        = 3'd7
  } vurp_sel_e;

  typedef struct packed {
    vurp_op_e   operation;
    vurp_sel_e  register_select;
    logic [7:0] write_value;
    logic [7:0] dma_index;
    logic [7:0] pattern_byte;
  } vurp_item_t;

endpackage

@@ src/vurp_channels.sv @@
interface vurp_in_if;
  import vurp_pkg::*;

  logic       valid;
  logic       ready;
  vurp_op_e   operation;
  vurp_sel_e  register_select;
  logic [7:0] write_value;
  logic [7:0] dma_index;
  logic [7:0] pattern_byte;

  modport source (
    output valid, operation, register_select, write_value, dma_index, pattern_byte,
    input  ready
  );
  modport sink (
    input  valid, operation, register_select, write_value, dma_index, pattern_byte,
    output ready
  );
endinterface

interface vurp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_value;
  logic        nmi_pending;
  logic [15:0] current_vram_address;

  modport source (
    output valid, read_value, nmi_pending, current_vram_address,
    input  ready
  );
  modport sink (
    input  valid, read_value, nmi_pending, current_vram_address,
    output ready
  );
endinterface

@@ src/video_unit_register_port_top.sv @@
// CPU-side register port of a tile video unit.
//
// Words arrive on in_i, a valid/ready channel. Each word is one bus access
// (register write or read), one sprite DMA byte, a vblank enter or leave
// event, or an NMI acknowledge. Every input word yields exactly one word on
// out_o: the byte read (zero for anything but a register read), the latched
// interrupt request and the VRAM pointer after the access.
//
// An accepted word reads the sprite, name and palette memories at the
// addresses the current state selects. In the execute state, once the
// output register is free, the registered read data is combined with the
// word, the registers and memories are written back and the result is
// loaded into the output register. A new word is taken only after that
// write-back; the synchronous read ahead of the write-back sets that.
//
// If the receiver stalls, the result stays in the output register and the
// next word is still accepted; its write-back then waits until the output
// register is free. Reset clears the architectural and output registers,
// but not the memories, which hold no data until written.
module video_unit_register_port_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  vurp_in_if.sink       in_i,
  vurp_out_if.source    out_o
);
  import vurp_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e      state_q;
  vurp_item_t  item_q;

  // Architectural registers.
  logic [7:0]  control_q, control_d;
  logic [7:0]  mask_q, mask_d;
  logic [7:0]  status_q, status_d;
  logic [7:0]  sprite_ptr_q, sprite_ptr_d;
  logic        toggle_q, toggle_d;
  logic [15:0] staging_q, staging_d;
  logic [15:0] vram_ptr_q, vram_ptr_d;
  logic [2:0]  fine_x_q, fine_x_d;
  logic [7:0]  read_latch_q, read_latch_d;
  logic        irq_q, irq_d;

  // Output register.
  logic        out_valid_q;
  logic [7:0]  out_read_q;
  logic [7:0]  read_d;

  // Memories and their registered read data.
  logic [7:0]  name_mem [NameBytes];
  logic [7:0]  sprite_mem [SpriteBytes];
  logic [7:0]  palette_mem [PaletteBytes];
  logic [7:0]  name_rdata_q;
  logic [7:0]  sprite_rdata_q;
  logic [7:0]  palette_rdata_q;

  logic        in_accept;
  logic        commit;

  // Address decode of the VRAM pointer. The pointer only changes at a
  // write-back, so the decode is the same at acceptance and at write-back.
  logic [15:0]          mirrored;
  logic [15:0]          name_off;
  logic                 pattern_hit;
  logic                 name_hit;
  logic                 palette_hit;
  logic [NameAw-1:0]    name_idx;
  logic [PaletteAw-1:0] pal_ridx;
  logic [PaletteAw-1:0] pal_widx;

  logic                 name_we;
  logic                 palette_we;
  logic                 sprite_we;
  logic [SpriteAw-1:0]  sprite_waddr;
  logic [7:0]           fetched;
  logic [15:0]          step;

  assign in_accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign commit = (state_q == ST_EXEC) && (!out_valid_q || out_o.ready);

  always_comb begin
    mirrored = vram_ptr_q;
    if (vram_ptr_q >= MirrorLo && vram_ptr_q <= MirrorHi) begin
      mirrored = vram_ptr_q - MirrorOffset;
    end
    name_off    = mirrored - NameBase;
    pattern_hit = (vram_ptr_q < NameBase);
    name_hit    = (mirrored >= NameBase) && (mirrored < MirrorLo) && (name_off < NameLimit);
    palette_hit = (vram_ptr_q >= PaletteBase) && (vram_ptr_q <= PaletteHi);
    name_idx    = name_off[NameAw-1:0];
    // The backdrop entry answers for every index that is a multiple of four.
    pal_ridx = vram_ptr_q[PaletteAw-1:0];
    if (pal_ridx[1:0] == 2'b00) begin
      pal_ridx = '0;
    end
    // Sprite backdrop indexes write through to the background entries.
    pal_widx = vram_ptr_q[PaletteAw-1:0];
    if (pal_widx[PaletteAw-1] && (pal_widx[1:0] == 2'b00)) begin
      pal_widx[PaletteAw-1] = 1'b0;
    end
  end

  always_comb begin
    if (pattern_hit) begin
      fetched = item_q.pattern_byte;
    end else if (name_hit) begin
      fetched = name_rdata_q;
    end else if (palette_hit) begin
      fetched = palette_rdata_q;
    end else begin
      fetched = UnmappedByte;
    end
  end

  assign step = control_q[2] ? StepWide : StepNarrow;

  // Next state of the registers for the word held in item_q.
  always_comb begin
    control_d    = control_q;
    mask_d       = mask_q;
    status_d     = status_q;
    sprite_ptr_d = sprite_ptr_q;
    toggle_d     = toggle_q;
    staging_d    = staging_q;
    vram_ptr_d   = vram_ptr_q;
    fine_x_d     = fine_x_q;
    read_latch_d = read_latch_q;
    irq_d        = irq_q;
    read_d       = 8'h00;
    name_we      = 1'b0;
    palette_we   = 1'b0;
    sprite_we    = 1'b0;
    sprite_waddr = sprite_ptr_q[SpriteAw-1:0];

    case (item_q.operation)
      OP_REG_WRITE: begin
        case (item_q.register_select)
          SEL_CONTROL: begin
            control_d = item_q.write_value;
            staging_d[11:10] = item_q.write_value[1:0];
          end
          SEL_MASK: mask_d = item_q.write_value;
          SEL_SPRITE_ADDR: sprite_ptr_d = item_q.write_value;
          SEL_SPRITE_DATA: sprite_we = 1'b1;
          SEL_SCROLL: begin
            if (!toggle_q) begin
              fine_x_d = item_q.write_value[2:0];
              staging_d[4:0] = item_q.write_value[7:3];
              toggle_d = 1'b1;
            end else begin
              staging_d[9:5] = item_q.write_value[7:3];
              staging_d[14:12] = item_q.write_value[2:0];
              toggle_d = 1'b0;
            end
          end
          SEL_ADDRESS: begin
            if (!toggle_q) begin
              staging_d[13:8] = item_q.write_value[5:0];
              staging_d[14] = 1'b0;
              toggle_d = 1'b1;
            end else begin
              staging_d[7:0] = item_q.write_value;
              vram_ptr_d = {staging_q[15:8], item_q.write_value};
              toggle_d = 1'b0;
            end
          end
          SEL_DATA: begin
            name_we    = name_hit;
            palette_we = palette_hit;
            vram_ptr_d = vram_ptr_q + step;
          end
          default: ;
        endcase
      end
      OP_REG_READ: begin
        case (item_q.register_select)
          SEL_STATUS: begin
            read_d = status_q;
            status_d[7] = 1'b0;
            toggle_d = 1'b0;
          end
          SEL_SPRITE_DATA: read_d = sprite_rdata_q;
          SEL_DATA: begin
            // Palette reads bypass the read buffer.
            read_d = palette_hit ? fetched : read_latch_q;
            read_latch_d = fetched;
            vram_ptr_d = vram_ptr_q + step;
          end
          default: ;
        endcase
      end
      OP_DMA_WRITE: begin
        sprite_we    = 1'b1;
        sprite_waddr = item_q.dma_index[SpriteAw-1:0];
      end
      OP_VBLANK_ENTER: begin
        status_d[7] = 1'b1;
        if (control_q[7]) begin
          irq_d = 1'b1;
        end
      end
      OP_VBLANK_LEAVE: status_d[7] = 1'b0;
      OP_NMI_ACK: irq_d = 1'b0;
      default: ;
    endcase
  end

  // Sequencer, registers and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      control_q    <= '0;
      mask_q       <= '0;
      status_q     <= '0;
      sprite_ptr_q <= '0;
      toggle_q     <= 1'b0;
      staging_q    <= '0;
      vram_ptr_q   <= '0;
      fine_x_q     <= '0;
      read_latch_q <= '0;
      irq_q        <= 1'b0;
      out_read_q   <= '0;
    end else begin
      // A new result takes the slot; otherwise a delivered one frees it.
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (commit) begin
            state_q      <= ST_IDLE;
            out_read_q   <= read_d;
            control_q    <= control_d;
            mask_q       <= mask_d;
            status_q     <= status_d;
            sprite_ptr_q <= sprite_ptr_d;
            toggle_q     <= toggle_d;
            staging_q    <= staging_d;
            vram_ptr_q   <= vram_ptr_d;
            fine_x_q     <= fine_x_d;
            read_latch_q <= read_latch_d;
            irq_q        <= irq_d;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Captured input word.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.operation       <= in_i.operation;
      item_q.register_select <= in_i.register_select;
      item_q.write_value     <= in_i.write_value;
      item_q.dma_index       <= in_i.dma_index;
      item_q.pattern_byte    <= in_i.pattern_byte;
    end
  end

  // Memories: read at acceptance, written at write-back. The two never fall
  // in the same cycle, so no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      name_rdata_q    <= name_mem[name_idx];
      sprite_rdata_q  <= sprite_mem[sprite_ptr_q[SpriteAw-1:0]];
      palette_rdata_q <= palette_mem[pal_ridx];
    end
    if (commit && name_we) begin
      name_mem[name_idx] <= item_q.write_value;
    end
    if (commit && palette_we) begin
      palette_mem[pal_widx] <= item_q.write_value;
    end
    if (commit && sprite_we) begin
      sprite_mem[sprite_waddr] <= item_q.write_value;
    end
  end

  assign out_o.valid                = out_valid_q;
  assign out_o.read_value           = out_read_q;
  assign out_o.nmi_pending          = irq_q;
  assign out_o.current_vram_address = vram_ptr_q;

`ifndef ASSERT_OFF
  a_accept_starts_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_EXEC))
    else $error("accepted word did not start a write-back");

  a_no_write_on_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> !in_accept)
    else $error("memory write-back coincides with a memory read");

  a_commit_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> (!out_valid_q || out_o.ready))
    else $error("result overwrote an undelivered result");

  a_status_read_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && item_q.operation == OP_REG_READ && item_q.register_select == SEL_STATUS)
    |=> (!toggle_q && !status_q[7]))
    else $error("status read did not clear toggle and vblank flag");
`endif

endmodule

@@ verif/video_unit_register_port_top_tb.sv @@
`timescale 1ns / 100ps

// Testbench of the CPU-side register port of the tile video unit.
//
// One process offers bus words on the input channel and another takes reply
// words from the output channel; both idle at random. A shadow of the port,
// kept in a small class, applies every accepted word to its own copy of the
// registers and memories and queues the reply that the word must produce.
// Every reply taken from the block is compared field by field with the
// oldest queued one.
//
// The memories hold no data until written, so the stimulus asks the shadow
// before each read of the sprite data port or the VRAM data port. If that
// read would reach a byte that was never written, the word is turned into a
// write of the same port instead, which defines the byte it writes.
module video_unit_register_port_top_tb;
  import vurp_pkg::*;

  localparam int unsigned ClockHalf   = 5;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned RandomWords = 500;
  // The sweep steps the pointer by 32 from the top of the palette far into
  // the unmapped space above it.
  localparam int unsigned SweepWords  = 300;
  // The sender never idles while this range of words goes out.
  localparam int unsigned CalmFrom    = 400;
  localparam int unsigned CalmTo      = 560;

  // The two operation codes that the block must accept and ignore.
  localparam logic [2:0] OpSpareLo = 3'd6;
  localparam logic [2:0] OpSpareHi = 3'd7;

  typedef struct packed {
    logic [7:0]  read_value;
    logic        nmi_pending;
    logic [15:0] vram_address;
  } port_reply_t;

  typedef enum {
    SPACE_PATTERN,
    SPACE_NAME,
    SPACE_PALETTE,
    SPACE_NONE
  } vram_space_e;

  // Shadow of the register port and the queue of replies it still owes.
  class vram_port_shadow;
    logic [7:0]  ctrl        = 8'h00;
    logic [7:0]  mask        = 8'h00;
    logic [7:0]  status      = 8'h00;
    logic [7:0]  sprite_addr = 8'h00;
    logic [7:0]  read_buf    = 8'h00;
    logic [2:0]  fine_x      = 3'd0;
    logic [15:0] staging     = 16'h0000;
    logic [15:0] vaddr       = 16'h0000;
    bit          addr_toggle = 1'b0;
    bit          nmi         = 1'b0;

    logic [7:0] sprite_mem [SpriteBytes];
    logic [7:0] name_mem   [NameBytes];
    logic [7:0] pal_mem    [PaletteBytes];
    bit         sprite_set [SpriteBytes];
    bit         name_set   [NameBytes];
    bit         pal_set    [PaletteBytes];

    port_reply_t pending_replies [$];
    int unsigned op_count [8];
    int unsigned errors = 0;

    // Folds the 0x3000 mirror and tells which store an address reaches.
    // Palette slots differ for reads (backdrop) and writes (mirror).
    function vram_space_e locate(input logic [15:0] a, input bit for_write,
                                 output int slot);
      logic [15:0] f;
      f = a;
      slot = 0;
      if (a < NameBase) return SPACE_PATTERN;
      if (a >= MirrorLo && a <= MirrorHi) f = a - MirrorOffset;
      if (f >= NameBase && f < MirrorLo) begin
        if (f - NameBase < NameLimit) begin
          slot = int'(f - NameBase);
          return SPACE_NAME;
        end
        return SPACE_NONE;
      end
      if (f >= PaletteBase && f <= PaletteHi) begin
        slot = int'(f[4:0]);
        if (for_write && (f[4:0] & 5'h13) == 5'h10) slot = int'(f[3:0]);
        if (!for_write && f[1:0] == 2'b00) slot = 0;
        return SPACE_PALETTE;
      end
      return SPACE_NONE;
    endfunction

    function bit fetch_defined();
      int slot;
      case (locate(vaddr, 1'b0, slot))
        SPACE_NAME:    return name_set[slot];
        SPACE_PALETTE: return pal_set[slot];
        default:       return 1'b1;
      endcase
    endfunction

    function bit sprite_defined();
      return sprite_set[sprite_addr];
    endfunction

    function logic [7:0] fetch_byte(input logic [7:0] pat);
      int slot;
      case (locate(vaddr, 1'b0, slot))
        SPACE_PATTERN: return pat;
        SPACE_NAME:    return name_mem[slot];
        SPACE_PALETTE: return pal_mem[slot];
        default:       return UnmappedByte;
      endcase
    endfunction

    function void store_byte(input logic [7:0] v);
      int slot;
      case (locate(vaddr, 1'b1, slot))
        SPACE_NAME: begin
          name_mem[slot] = v;
          name_set[slot] = 1'b1;
        end
        SPACE_PALETTE: begin
          pal_mem[slot] = v;
          pal_set[slot] = 1'b1;
        end
        default: ;
      endcase
    endfunction

    function void step_pointer();
      vaddr = vaddr + (ctrl[2] ? StepWide : StepNarrow);
    endfunction

    function void write_register(input vurp_sel_e sel, input logic [7:0] v);
      case (sel)
        SEL_CONTROL: begin
          ctrl = v;
          staging[11:10] = v[1:0];
        end
        SEL_MASK:        mask = v;
        SEL_SPRITE_ADDR: sprite_addr = v;
        SEL_SPRITE_DATA: begin
          sprite_mem[sprite_addr] = v;
          sprite_set[sprite_addr] = 1'b1;
        end
        SEL_SCROLL: begin
          if (!addr_toggle) begin
            fine_x = v[2:0];
            staging[4:0] = v[7:3];
          end else begin
            staging[9:5] = v[7:3];
            staging[14:12] = v[2:0];
          end
          addr_toggle = !addr_toggle;
        end
        SEL_ADDRESS: begin
          if (!addr_toggle) begin
            staging[13:8] = v[5:0];
            staging[14] = 1'b0;
          end else begin
            staging[7:0] = v;
            vaddr = staging;
          end
          addr_toggle = !addr_toggle;
        end
        SEL_DATA: begin
          store_byte(v);
          step_pointer();
        end
        default: ;
      endcase
    endfunction

    function logic [7:0] read_register(input vurp_sel_e sel, input logic [7:0] pat);
      logic [7:0] value;
      value = 8'h00;
      case (sel)
        SEL_STATUS: begin
          value = status;
          status[7] = 1'b0;
          addr_toggle = 1'b0;
        end
        SEL_SPRITE_DATA: value = sprite_mem[sprite_addr];
        SEL_DATA: begin
          // Buffered read, except that palette bytes come back at once.
          value = read_buf;
          read_buf = fetch_byte(pat);
          if (vaddr >= PaletteBase && vaddr <= PaletteHi) value = read_buf;
          step_pointer();
        end
        default: ;
      endcase
      return value;
    endfunction

    function port_reply_t apply_word(input vurp_item_t w);
      port_reply_t r;
      r.read_value = 8'h00;
      case (w.operation)
        OP_REG_WRITE: write_register(w.register_select, w.write_value);
        OP_REG_READ:  r.read_value = read_register(w.register_select, w.pattern_byte);
        OP_DMA_WRITE: begin
          sprite_mem[w.dma_index] = w.write_value;
          sprite_set[w.dma_index] = 1'b1;
        end
        OP_VBLANK_ENTER: begin
          status[7] = 1'b1;
          if (ctrl[7]) nmi = 1'b1;
        end
        OP_VBLANK_LEAVE: status[7] = 1'b0;
        OP_NMI_ACK:      nmi = 1'b0;
        default: ;
      endcase
      r.nmi_pending = nmi;
      r.vram_address = vaddr;
      return r;
    endfunction

    function void note_word(input vurp_item_t w);
      op_count[w.operation]++;
      pending_replies.push_back(apply_word(w));
    endfunction

    function void check_reply(input port_reply_t got);
      port_reply_t want;
      if (pending_replies.size() == 0) begin
        $error("reply word with none outstanding: read_value %h nmi_pending %b address %h",
               got.read_value, got.nmi_pending, got.vram_address);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %h, actual %h", want.read_value, got.read_value);
        errors++;
      end
      if (got.nmi_pending !== want.nmi_pending) begin
        $error("nmi_pending: expected %b, actual %b", want.nmi_pending, got.nmi_pending);
        errors++;
      end
      if (got.vram_address !== want.vram_address) begin
        $error("current_vram_address: expected %h, actual %h",
               want.vram_address, got.vram_address);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  vurp_in_if  in_if ();
  vurp_out_if out_if ();

  vram_port_shadow shadow = new;
  int unsigned words_sent = 0;

  video_unit_register_port_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #ClockHalf clk_i = ~clk_i;

  // Offers one word and returns at the edge where the block takes it. The
  // shadow sees the word right there, so the next word is generated against
  // the state that this one leaves behind. Reads that would reach a byte
  // never written become writes of the same port.
  task automatic send_word(input logic [2:0] op, input vurp_sel_e sel,
                           input logic [7:0] val, input logic [7:0] idx,
                           input logic [7:0] pat);
    vurp_item_t w;
    if (op == OP_REG_READ && sel == SEL_SPRITE_DATA && !shadow.sprite_defined())
      op = OP_REG_WRITE;
    if (op == OP_REG_READ && sel == SEL_DATA && !shadow.fetch_defined())
      op = OP_REG_WRITE;
    w = '{operation: vurp_op_e'(op), register_select: sel, write_value: val,
          dma_index: idx, pattern_byte: pat};
    // Random bubbles of random length, except in the calm stretch.
    if (words_sent < CalmFrom || words_sent >= CalmTo) begin
      while ($urandom_range(0, 99) < 14) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_if.valid           <= 1'b1;
    in_if.operation       <= w.operation;
    in_if.register_select <= w.register_select;
    in_if.write_value     <= w.write_value;
    in_if.dma_index       <= w.dma_index;
    in_if.pattern_byte    <= w.pattern_byte;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    shadow.note_word(w);
    words_sent++;
  endtask

  task automatic reg_write(input vurp_sel_e sel, input logic [7:0] val);
    send_word(OP_REG_WRITE, sel, val, 8'($urandom), 8'($urandom));
  endtask

  task automatic reg_read(input vurp_sel_e sel);
    send_word(OP_REG_READ, sel, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Loads the VRAM pointer through the address register. A pending first
  // write is cleared by a status read, as driver code does.
  task automatic aim_pointer(input logic [15:0] a);
    if (shadow.addr_toggle) reg_read(SEL_STATUS);
    reg_write(SEL_ADDRESS, {2'($urandom), a[13:8]});
    reg_write(SEL_ADDRESS, a[7:0]);
  endtask

  // Target of a data burst: mostly small windows of the nametable and the
  // palette so that later readbacks find written bytes, plus pattern space,
  // the unmapped holes and the edge into the space above 0x3FFF.
  function automatic logic [15:0] pick_target();
    logic [15:0] mirror;
    mirror = $urandom_range(0, 1) ? MirrorOffset : 16'h0000;
    case ($urandom_range(0, 9))
      0, 1, 2: return NameBase + mirror + 16'($urandom_range(0, 63));
      3:       return 16'h27F0 + mirror + 16'($urandom_range(0, 15));
      4, 5:    return PaletteBase + 16'($urandom_range(0, 255));
      6:       return 16'($urandom_range(0, 16'h1FFF));
      7:       return 16'($urandom_range(16'h2800, 16'h2FFF)) + mirror;
      8:       return 16'h3FF0 + 16'($urandom_range(0, 15));
      default: return 16'($urandom_range(0, 16'h3FFF));
    endcase
  endfunction

  // Every reply that the block hands over is checked against the shadow.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      shadow.check_reply({out_if.read_value, out_if.nmi_pending,
                          out_if.current_vram_address});
  end

  // Receiver. Mostly random stalls, a stretch with none at all, and two long
  // hold-offs during which the sender keeps offering words, so the block
  // fills its output register and then stalls its input.
  initial begin : reply_sink
    int unsigned tick;
    tick = 0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ((tick >= 300 && tick < 360) || (tick >= 1500 && tick < 1560))
        out_if.ready <= 1'b0;
      else if (tick >= 800 && tick < 1200)
        out_if.ready <= 1'b1;
      else
        out_if.ready <= ($urandom_range(0, 99) >= 14);
      tick++;
      @(posedge clk_i);
    end
  end

  // Ends the run if the block stops making progress.
  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("video_unit_register_port_top test failed");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] burst_base;
    logic [7:0]  sprite_start;
    int unsigned run_len;
    int unsigned directed_end;
    int unsigned n;

    in_if.valid           <= 1'b0;
    in_if.operation       <= OP_REG_WRITE;
    in_if.register_select <= SEL_CONTROL;
    in_if.write_value     <= 8'h00;
    in_if.dma_index       <= 8'h00;
    in_if.pattern_byte    <= 8'h00;
    burst_base = NameBase;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Status is zero after reset and write-only registers
    // read as zero; a status write is dropped.
    reg_read(SEL_STATUS);
    reg_read(SEL_CONTROL);
    reg_write(SEL_STATUS, 8'hFF);
    // Interrupt enable, step of 32. Vblank latches the request, the status
    // read returns the vblank bit and clears it, the acknowledge drops the
    // request. Leaving vblank keeps a latched request.
    reg_write(SEL_CONTROL, 8'h87);
    send_word(OP_VBLANK_ENTER, SEL_CONTROL, 8'h00, 8'h00, 8'h00);
    reg_read(SEL_STATUS);
    send_word(OP_NMI_ACK, SEL_CONTROL, 8'h00, 8'h00, 8'h00);
    send_word(OP_VBLANK_ENTER, SEL_CONTROL, 8'h00, 8'h00, 8'h00);
    send_word(OP_VBLANK_LEAVE, SEL_CONTROL, 8'h00, 8'h00, 8'h00);
    // Unused operation codes with every other field at its top value.
    send_word(OpSpareLo, SEL_DATA, 8'hFF, 8'hFF, 8'hFF);
    send_word(OpSpareHi, SEL_DATA, 8'hFF, 8'hFF, 8'hFF);
    // Sprite DMA to the last byte, read it back through the data port; a
    // data write does not move the sprite address.
    send_word(OP_DMA_WRITE, SEL_STATUS, 8'hA5, 8'hFF, 8'h00);
    reg_write(SEL_SPRITE_ADDR, 8'hFF);
    reg_read(SEL_SPRITE_DATA);
    reg_write(SEL_SPRITE_DATA, 8'h3C);
    reg_read(SEL_SPRITE_DATA);
    // A write to palette 0x10 lands in the backdrop entry. The top bits of
    // the first address byte are masked off.
    reg_write(SEL_ADDRESS, 8'hFF);
    reg_write(SEL_ADDRESS, 8'h10);
    reg_write(SEL_DATA, 8'h21);
    // Palette reads bypass the buffer, and 0x3F20 reads the backdrop.
    aim_pointer(PaletteBase);
    reg_read(SEL_DATA);
    reg_read(SEL_DATA);
    // Mixed order on the shared toggle: address high, scroll second half,
    // control nametable bits, scroll first half, address low. The pointer
    // lands at 0x7FFF, far in unmapped space.
    reg_write(SEL_ADDRESS, 8'h00);
    reg_write(SEL_SCROLL, 8'hFF);
    reg_write(SEL_CONTROL, 8'h03);
    reg_write(SEL_SCROLL, 8'hFF);
    reg_write(SEL_ADDRESS, 8'hFF);
    reg_read(SEL_DATA);
    directed_end = words_sent;

    // Random part, mostly well-formed driver sequences with random content.
    while (words_sent < directed_end + RandomWords) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // Data burst: new control byte (step, interrupt enable, nametable
          // bits), pointer load, a run of data writes.
          reg_write(SEL_CONTROL, 8'($urandom));
          burst_base = pick_target();
          aim_pointer(burst_base);
          repeat ($urandom_range(1, 8))
            reg_write(SEL_DATA, 8'($urandom));
        end
        2, 3: begin
          // Readback, usually of the last burst, through the read buffer.
          aim_pointer(($urandom_range(0, 3) != 0) ? burst_base : pick_target());
          repeat ($urandom_range(2, 9)) reg_read(SEL_DATA);
        end
        4: begin
          // Sprite DMA run, then the sprite address and data port.
          sprite_start = 8'($urandom);
          run_len = $urandom_range(1, 8);
          for (n = 0; n < run_len; n++)
            send_word(OP_DMA_WRITE, vurp_sel_e'(3'($urandom)), 8'($urandom),
                      sprite_start + 8'(n), 8'($urandom));
          reg_write(SEL_SPRITE_ADDR, sprite_start + 8'($urandom_range(0, run_len - 1)));
          reg_read(SEL_SPRITE_DATA);
          reg_write(SEL_SPRITE_DATA, 8'($urandom));
          reg_read(SEL_SPRITE_DATA);
        end
        5: begin
          // Frame: maybe a control byte, vblank, maybe a status poll and an acknowledge, leave.
          if ($urandom_range(0, 2) == 0) reg_write(SEL_CONTROL, 8'($urandom));
          send_word(OP_VBLANK_ENTER, vurp_sel_e'(3'($urandom)), 8'($urandom),
                    8'($urandom), 8'($urandom));
          if ($urandom_range(0, 1)) reg_read(SEL_STATUS);
          if ($urandom_range(0, 1))
            send_word(OP_NMI_ACK, vurp_sel_e'(3'($urandom)), 8'($urandom),
                      8'($urandom), 8'($urandom));
          send_word(OP_VBLANK_LEAVE, vurp_sel_e'(3'($urandom)), 8'($urandom),
                    8'($urandom), 8'($urandom));
        end
        6: begin
          // Scroll and address writes in any order on the shared toggle, maybe then a data read.
          repeat ($urandom_range(2, 4))
            reg_write($urandom_range(0, 1) ? SEL_SCROLL : SEL_ADDRESS, 8'($urandom));
          if ($urandom_range(0, 1)) reg_read(SEL_DATA);
        end
        default: begin
          // Noise: any code, any register, any values.
          repeat ($urandom_range(1, 4))
            send_word(3'($urandom), vurp_sel_e'(3'($urandom)), 8'($urandom),
                      8'($urandom), 8'($urandom));
        end
      endcase
    end

    // Pointer sweep with a step of 32 from the top of the palette into the
    // unmapped space above it.
    reg_write(SEL_CONTROL, 8'($urandom) | 8'h04);
    aim_pointer(16'h3FE0 | 16'($urandom_range(0, 31)));
    repeat (SweepWords) begin
      if ($urandom_range(0, 3) == 0)
        reg_write(SEL_DATA, 8'($urandom));
      else
        reg_read(SEL_DATA);
    end

    in_if.valid <= 1'b0;
    while (shadow.pending_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d words: %0d register writes, %0d register reads, %0d DMA bytes,",
             words_sent, shadow.op_count[OP_REG_WRITE], shadow.op_count[OP_REG_READ],
             shadow.op_count[OP_DMA_WRITE]);
    $display("%0d vblank and acknowledge events, %0d unused codes; %0d mismatches.",
             shadow.op_count[OP_VBLANK_ENTER] + shadow.op_count[OP_VBLANK_LEAVE]
               + shadow.op_count[OP_NMI_ACK],
             shadow.op_count[OpSpareLo] + shadow.op_count[OpSpareHi], shadow.errors);
    if (shadow.errors == 0) begin
      $display("video_unit_register_port_top test passed");
    end else begin
      $display("video_unit_register_port_top test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/vurp_pkg.sv
src/vurp_channels.sv
src/video_unit_register_port_top.sv
verif/video_unit_register_port_top_tb.sv
